FILE: design/per_channel_peak_level_meter_assert.svh
// Assertion macros used by the checker of the peak level meter.
`ifndef PER_CHANNEL_PEAK_LEVEL_METER_ASSERT_SVH
`define PER_CHANNEL_PEAK_LEVEL_METER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define PCLM_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PCLM_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

FILE: design/pclm_pkg.sv
// Shared types, constants and functions of the peak level meter.
package pclm_pkg;

  // Default channel capacity of the meter.
  localparam int DEFAULT_MAX_CHANNELS = 8;

  // Field widths.
  localparam int SAMPLE_W    = 32;
  localparam int LEVEL_W     = 17;
  localparam int CHANNEL_W   = 3;
  localparam int FMT_W       = 3;
  localparam int COUNT_W     = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;
  localparam int M_TDATA_W   = 24;

  // Effective channel count width, enough for counts up to 32.
  localparam int CNT_W = 6;

  // Sample formats.
  localparam logic [FMT_W-1:0] FMT_S8  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_S32 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_U8  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_U16 = 3'd4;
  localparam logic [FMT_W-1:0] FMT_U32 = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_FORMAT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [FMT_W-1:0]   FMT_RESET   = FMT_S16;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;

  // Level of 1.0 in Q1.16.
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;

  // One channel peak handed from the front end to the level unit.
  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  peak;
    logic                 last;
  } pclm_job_t;

  // Magnitude of a raw sample in the given format.
  function automatic logic [SAMPLE_W-1:0] sample_magnitude(
    input logic [FMT_W-1:0]    fmt,
    input logic [SAMPLE_W-1:0] raw
  );
    logic [8:0]  m8;
    logic [16:0] m16;
    logic [SAMPLE_W-1:0] res;
    m8  = raw[7] ? (9'h100 - {1'b0, raw[7:0]}) : {1'b0, raw[7:0]};
    m16 = raw[15] ? (17'h10000 - {1'b0, raw[15:0]}) : {1'b0, raw[15:0]};
    case (fmt)
      FMT_S8:  res = {23'd0, m8};
      FMT_S16: res = {15'd0, m16};
      FMT_S32: res = raw[31] ? (32'd0 - raw) : raw;
      FMT_U16: res = {16'd0, raw[15:0]};
      FMT_U32: res = raw;
      default: res = {24'd0, raw[7:0]};
    endcase
    return res;
  endfunction

  // Full scale of a format; zero for the undefined codes.
  function automatic logic [SAMPLE_W-1:0] full_scale(input logic [FMT_W-1:0] fmt);
    logic [SAMPLE_W-1:0] res;
    case (fmt)
      FMT_S8:  res = 32'd127;
      FMT_S16: res = 32'd32767;
      FMT_S32: res = 32'd2147483647;
      FMT_U8:  res = 32'd255;
      FMT_U16: res = 32'd65535;
      FMT_U32: res = 32'hFFFF_FFFF;
      default: res = 32'd0;
    endcase
    return res;
  endfunction

endpackage

FILE: design/pclm_front.sv
// Front end: tracks per-channel peaks and hands them out at each buffer end.
module pclm_front #(
  parameter int MAX_CHANNELS = pclm_pkg::DEFAULT_MAX_CHANNELS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pclm_pkg::FMT_W-1:0]    sample_format,
  input  logic [pclm_pkg::COUNT_W-1:0]  channel_count,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pclm_pkg::SAMPLE_W-1:0] s_tdata,
  input  logic                          s_tlast,
  output logic                          job_valid,
  input  logic                          job_ready,
  output pclm_pkg::pclm_job_t           job
);

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W  = pclm_pkg::CNT_W;
  localparam int CHAN_W = pclm_pkg::CHANNEL_W;
  localparam int SMP_W  = pclm_pkg::SAMPLE_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHANNELS);

  logic [SMP_W-1:0] peak [MAX_CHANNELS];
  logic [CH_W-1:0]  pos;
  logic [CH_W-1:0]  drain_idx;
  logic             draining;

  logic [CNT_W-1:0] count_ext;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] pos_ext;
  logic [CNT_W-1:0] ch_next_ext;
  logic [CNT_W-1:0] drain_next_ext;
  logic [CH_W-1:0]  ch;
  logic [CH_W-1:0]  pos_next;
  logic [CH_W-1:0]  rd_addr;
  logic [SMP_W-1:0] peak_rd;
  logic [SMP_W-1:0] mag;
  logic             accept;
  logic             drain_last;

  // Effective channel count, clamped to one through the capacity.
  assign count_ext = {{(CNT_W - pclm_pkg::COUNT_W){1'b0}}, channel_count};
  always_comb begin
    if (channel_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (count_ext > MAX_CNT) begin
      n_eff = MAX_CNT;
    end else begin
      n_eff = count_ext;
    end
  end

  // Channel of this sample and the counter value after it.
  assign pos_ext     = CNT_W'(pos);
  assign ch          = (pos_ext >= n_eff) ? '0 : pos;
  assign ch_next_ext = CNT_W'(ch) + CNT_W'(1);
  assign pos_next    = (ch_next_ext >= n_eff) ? '0 : ch_next_ext[CH_W-1:0];

  // One read port into the peak registers, shared by update and drain.
  assign rd_addr = draining ? drain_idx : ch;
  assign peak_rd = peak[rd_addr];
  assign mag     = pclm_pkg::sample_magnitude(sample_format, s_tdata);

  assign s_tready = !draining;
  assign accept   = s_tvalid && s_tready;

  assign drain_next_ext = CNT_W'(drain_idx) + CNT_W'(1);
  assign drain_last     = (drain_next_ext == n_eff);

  // Drain side: one channel peak per transaction into the queue.
  assign job_valid   = draining;
  assign job.channel = CHAN_W'(drain_idx);
  assign job.peak    = peak_rd;
  assign job.last    = drain_last;

  // Peak update, counter and drain sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      draining  <= 1'b0;
      pos       <= '0;
      drain_idx <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        peak[i] <= '0;
      end
    end else begin
      if (accept) begin
        if (mag > peak_rd) begin
          peak[ch] <= mag;
        end
        if (s_tlast) begin
          draining  <= 1'b1;
          drain_idx <= '0;
          pos       <= '0;
        end else begin
          pos <= pos_next;
        end
      end
      if (draining && job_ready) begin
        if (drain_last) begin
          draining <= 1'b0;
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            peak[i] <= '0;
          end
        end else begin
          drain_idx <= drain_next_ext[CH_W-1:0];
        end
      end
    end
  end

endmodule

FILE: design/pclm_fifo.sv
// Two-entry queue between the front end and the level unit.
module pclm_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  pclm_pkg::pclm_job_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output pclm_pkg::pclm_job_t pop_data
);

  pclm_pkg::pclm_job_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

FILE: design/pclm_back.sv
// Level unit: scales one channel peak to Q1.16 by folding modulo the full scale.
module pclm_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [pclm_pkg::FMT_W-1:0]     sample_format,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  pclm_pkg::pclm_job_t            job,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pclm_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast
);

  localparam int LVL_W  = pclm_pkg::LEVEL_W;
  localparam int SMP_W  = pclm_pkg::SAMPLE_W;
  localparam int NUM_W  = SMP_W + 2;
  localparam int FRAC_W = LVL_W - 1;
  localparam int RED_W  = SMP_W + FRAC_W;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_NUM  = 3'd1;
  localparam logic [2:0] B_LOAD = 3'd2;
  localparam logic [2:0] B_RED  = 3'd3;
  localparam logic [2:0] B_DONE = 3'd4;

  logic [2:0]          state;
  pclm_pkg::pclm_job_t job_q;
  logic [NUM_W-1:0]    num;
  logic [RED_W-1:0]    red;
  logic [LVL_W-1:0]    quo;
  logic                sat;

  logic [SMP_W-1:0]    full;
  logic [NUM_W-1:0]    full_ext;
  logic [SMP_W-1:0]    half;
  logic [NUM_W-1:0]    twice;
  logic [NUM_W-1:0]    num_calc;
  logic                fmt_signed;
  logic                fmt_valid;
  logic [RED_W-1:0]    red_hi;
  logic [RED_W-1:0]    red_lo;
  logic                round_up;
  logic [LVL_W-1:0]    quo_round;
  logic [LVL_W-1:0]    level_calc;
  logic                out_load;

  // Format decode.
  always_comb begin
    full       = pclm_pkg::full_scale(sample_format);
    fmt_signed = sample_format inside {pclm_pkg::FMT_S8, pclm_pkg::FMT_S16,
                                       pclm_pkg::FMT_S32};
    fmt_valid  = fmt_signed || (sample_format inside {pclm_pkg::FMT_U8,
                                pclm_pkg::FMT_U16, pclm_pkg::FMT_U32});
  end
  assign full_ext = {2'b00, full};
  assign half     = {1'b0, full[SMP_W-1:1]} + SMP_W'(1);

  // Numerator: the peak itself, or its distance from mid scale times two.
  assign twice = {1'b0, job_q.peak, 1'b0};
  always_comb begin
    if (fmt_signed) begin
      num_calc = {2'b00, job_q.peak};
    end else if (twice >= full_ext) begin
      num_calc = twice - full_ext;
    end else begin
      num_calc = full_ext - twice;
    end
  end

  // Every full scale is 2^k - 1, so hi * 2^k + lo equals hi * F + (hi + lo).
  // Folding the high part into the low part keeps the value modulo F while
  // hi adds to the quotient; it ends once the value is below 2^k.
  always_comb begin
    case (sample_format)
      pclm_pkg::FMT_S8:  red_hi = red >> 7;
      pclm_pkg::FMT_S16: red_hi = red >> 15;
      pclm_pkg::FMT_S32: red_hi = red >> 31;
      pclm_pkg::FMT_U16: red_hi = red >> 16;
      pclm_pkg::FMT_U32: red_hi = red >> 32;
      default:           red_hi = red >> 8;
    endcase
  end
  assign red_lo = red & {{FRAC_W{1'b0}}, full};

  // A remainder of half the full scale or more rounds up; this also covers a
  // remainder equal to the full scale, which is one more whole quotient.
  assign round_up  = (red >= {{FRAC_W{1'b0}}, half});
  assign quo_round = quo + {{(LVL_W-1){1'b0}}, round_up};

  // Final clamp to 1.0; undefined formats read zero.
  always_comb begin
    if (!fmt_valid) begin
      level_calc = '0;
    end else if (sat || (quo_round > pclm_pkg::LEVEL_ONE)) begin
      level_calc = pclm_pkg::LEVEL_ONE;
    end else begin
      level_calc = quo_round;
    end
  end

  assign job_ready = (state == B_IDLE);
  assign out_load  = (state == B_DONE) && (!m_tvalid || m_tready);

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          job_q <= job;
        end
      end
      B_NUM: begin
        num <= num_calc;
      end
      B_LOAD: begin
        red <= {num[SMP_W-1:0], {FRAC_W{1'b0}}};
        quo <= '0;
        sat <= (num > full_ext);
      end
      B_RED: begin
        if (red_hi != '0) begin
          red <= red_hi + red_lo;
          quo <= quo + red_hi[LVL_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            state <= B_NUM;
          end
        end
        B_NUM: begin
          state <= B_LOAD;
        end
        B_LOAD: begin
          state <= ((num > full_ext) || !fmt_valid) ? B_DONE : B_RED;
        end
        B_RED: begin
          if (red_hi == '0) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_load) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Output payload, loaded with the valid flag.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(pclm_pkg::M_TDATA_W - LVL_W - pclm_pkg::CHANNEL_W){1'b0}},
                  level_calc, job_q.channel};
      m_tlast <= job_q.last;
    end
  end

endmodule

FILE: design/per_channel_peak_level_meter.sv
// Top level of the per-channel peak level meter.
//
//  Channel | Direction | Signals                      | Contents
//  s       | in        | s_tvalid s_tready s_tdata    | sample[31:0]; s_tlast = end_of_buffer
//  m       | out       | m_tvalid m_tready m_tdata    | channel[2:0], level[19:3], zero pad
//          |           | m_tlast                      | last_channel
//  cfg     | in        | cfg_wr_en cfg_index cfg_data | 0 sample_format, 1 channel_count
//
// After a buffer end s_tready stays low while the front end queues one peak per
// cycle into a two-entry queue, waiting on the level unit when the queue is full.
// For each channel the level unit steps through accept, operand, load, folding
// and the output load, skipping the folding on a saturated level or undefined
// format; a low m_tready holds it. Reset is synchronous: peaks and counter clear,
// format signed16, channel count two.
module per_channel_peak_level_meter #(
  parameter int MAX_CHANNELS = pclm_pkg::DEFAULT_MAX_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst,
  // Sample stream: tdata = sample[31:0].
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pclm_pkg::SAMPLE_W-1:0]    s_tdata,
  input  logic                             s_tlast,
  // Level stream: tdata = channel[2:0], level[19:3], zeros[23:20].
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pclm_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                             m_tlast,
  // Configuration writes.
  input  logic                             cfg_wr_en,
  input  logic [pclm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pclm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [pclm_pkg::FMT_W-1:0]   sample_format;
  logic [pclm_pkg::COUNT_W-1:0] channel_count;

  pclm_pkg::pclm_job_t front_job;
  pclm_pkg::pclm_job_t back_job;
  logic                front_valid;
  logic                front_ready;
  logic                back_valid;
  logic                back_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= pclm_pkg::FMT_RESET;
      channel_count <= pclm_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pclm_pkg::CFG_SAMPLE_FORMAT: sample_format <= cfg_data[pclm_pkg::FMT_W-1:0];
        pclm_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pclm_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_format (sample_format),
    .channel_count (channel_count),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .job_valid     (front_valid),
    .job_ready     (front_ready),
    .job           (front_job)
  );

  pclm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_job)
  );

  pclm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .sample_format (sample_format),
    .job_valid     (back_valid),
    .job_ready     (back_ready),
    .job           (back_job),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast)
  );

endmodule

FILE: design/pclm_checker.sv
// Port-level checks of the peak level meter, bound to the top level.
`include "per_channel_peak_level_meter_assert.svh"

module pclm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           s_tlast,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [pclm_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tlast
);

  // A stalled level result keeps its payload.
  `PCLM_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "level result changed while stalled")

  // No level ever exceeds 1.0.
  `PCLM_ASSERT(a_level_max, clk, rst, m_tvalid |-> m_tdata[19:3] <= 17'd65536, "level above full scale")

  // The sample stream pauses right after a buffer end while peaks drain.
  `PCLM_ASSERT(a_drain_stall, clk, rst, s_tvalid && s_tready && s_tlast |=> !s_tready, "sample taken during peak drain")

  // Reset leaves no result pending.
  `PCLM_ASSERT_ALWAYS(a_reset_out, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind per_channel_peak_level_meter pclm_checker u_pclm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
